/* design/signed_integer_to_seven_segment_unit_macros.svh */
// ============================================================================
// Assertion macros for the signed integer to seven-segment unit
// Shared helpers for clocked, reset-qualified concurrent checks.
// ============================================================================
`ifndef SIGNED_INTEGER_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH
`define SIGNED_INTEGER_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define SITS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("seven-segment unit check failed");

// Check that the consequent follows whenever the antecedent holds.
`define SITS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("seven-segment unit check failed");

`endif

/* design/sits_pkg.sv */
// ============================================================================
// sits_pkg
// Types, segment codes and arithmetic helpers for the seven-segment unit.
// ============================================================================
package sits_pkg;

    localparam logic [7:0]  SEG_MINUS = 8'h40;
    localparam logic [7:0]  SEG_BLANK = 8'h00;
    localparam logic [7:0]  SEG_DOT   = 8'h80;
    localparam logic [13:0] MAG_LIMIT = 14'd9999;
    localparam logic [16:0] NEG_LIMIT = 17'd999;
    localparam logic [16:0] NEG_BASE  = 17'h10000;
    // floor(x / 10) == (x * DIV10_MUL) >> 16 for every x below 16384
    localparam logic [27:0] DIV10_MUL = 28'd6554;
    localparam logic [13:0] TEN       = 14'd10;
    localparam int          LATENCY   = 5;

    typedef struct packed {
        logic              mode;
        logic signed [15:0] number;
        logic              zero_pad;
        logic [7:0]        dot_pos;
    } item_t;

    typedef struct packed {
        logic [7:0] seg_first;
        logic [7:0] seg_second;
        logic [7:0] seg_third;
        logic [7:0] seg_fourth;
    } result_t;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic       mode;
        logic       neg;
        logic       neg_big;
        logic       lz;
        logic [7:0] dot;
    } ctl_t;

    function automatic logic [7:0] digit_code(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h3F;
            4'd1:    c = 8'h06;
            4'd2:    c = 8'h5B;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h66;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h7D;
            4'd7:    c = 8'h07;
            4'd8:    c = 8'h7F;
            4'd9:    c = 8'h6F;
            default: c = SEG_BLANK;
        endcase
        return c;
    endfunction

    function automatic logic [13:0] div10(input logic [13:0] x);
        logic [27:0] prod;
        prod = {14'd0, x} * DIV10_MUL;
        return {2'd0, prod[27:16]};
    endfunction

    function automatic logic [3:0] mod10(input logic [13:0] x, input logic [13:0] q);
        logic [27:0] qx;
        logic [13:0] r;
        qx = {14'd0, q} * {14'd0, TEN};
        r  = x - qx[13:0];
        return r[3:0];
    endfunction

endpackage

/* design/signed_integer_to_seven_segment_unit.sv */
// ============================================================================
// signed_integer_to_seven_segment_unit
// Turns a signed 16-bit number into four seven-segment codes.
// ============================================================================
// Pipeline: an item is registered in stages 1 to 4, then in the output register.
// Throughput: one item per cycle; busy is always low, a new item may follow
// every cycle and each one costs one multiply-by-reciprocal per digit stage.
// Reset: rst_n clears all valid bits at once, so no result strobes after
// reset until an item has traveled the full pipeline; payload is not reset.
module signed_integer_to_seven_segment_unit
    import sits_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    // ------------------------------------------------------------------
    // Stage 1: magnitude, saturation and the all-minus case
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    ctl_t        s1_ctl_reg,  s1_ctl_next;
    logic [13:0] s1_mag_reg,  s1_mag_next;

    logic [16:0] mag_full;
    logic        in_neg;

    assign busy = 1'b0;  // every stage advances each cycle, so never hold off

    always_comb
    begin
        in_neg   = item.number[15];
        mag_full = in_neg ? (NEG_BASE - {1'b0, item.number}) : {1'b0, item.number};
        s1_mag_next = (mag_full > {3'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_full[13:0];
        s1_ctl_next.mode    = item.mode;
        s1_ctl_next.neg     = in_neg;
        s1_ctl_next.neg_big = in_neg && (mag_full > NEG_LIMIT);
        s1_ctl_next.lz      = item.zero_pad;
        s1_ctl_next.dot     = item.dot_pos;
    end

    // ------------------------------------------------------------------
    // Stage 2: units digit and first quotient
    // ------------------------------------------------------------------
    logic        s2_valid_reg;
    ctl_t        s2_ctl_reg;
    logic [9:0]  s2_q_reg,  s2_q_next;
    logic [3:0]  s2_d0_reg, s2_d0_next;

    logic [13:0] q1_full;

    always_comb
    begin
        q1_full    = div10(s1_mag_reg);
        s2_q_next  = q1_full[9:0];
        s2_d0_next = mod10(s1_mag_reg, q1_full);
    end

    // ------------------------------------------------------------------
    // Stage 3: tens digit and second quotient
    // ------------------------------------------------------------------
    logic        s3_valid_reg;
    ctl_t        s3_ctl_reg;
    logic [6:0]  s3_q_reg,  s3_q_next;
    logic [3:0]  s3_d0_reg;
    logic [3:0]  s3_d1_reg, s3_d1_next;
    logic        s3_show2_reg, s3_show2_next;

    logic [13:0] q2_full;

    always_comb
    begin
        q2_full       = div10({4'd0, s2_q_reg});
        s3_q_next     = q2_full[6:0];
        s3_d1_next    = mod10({4'd0, s2_q_reg}, q2_full);
        s3_show2_next = (s2_q_reg != 10'd0);
    end

    // ------------------------------------------------------------------
    // Stage 4: hundreds and thousands digits
    // ------------------------------------------------------------------
    logic        s4_valid_reg;
    ctl_t        s4_ctl_reg;
    logic [3:0]  s4_d0_reg, s4_d1_reg;
    logic [3:0]  s4_d2_reg, s4_d2_next;
    logic [3:0]  s4_d3_reg, s4_d3_next;
    logic        s4_show2_reg;
    logic        s4_show1_reg, s4_show1_next;
    logic        s4_show0_reg, s4_show0_next;

    logic [13:0] q3_full;

    always_comb
    begin
        q3_full       = div10({7'd0, s3_q_reg});
        s4_d3_next    = q3_full[3:0];
        s4_d2_next    = mod10({7'd0, s3_q_reg}, q3_full);
        s4_show1_next = (s3_q_reg != 7'd0);
        s4_show0_next = (q3_full != 14'd0);
    end

    // ------------------------------------------------------------------
    // Stage 5: segment encoding, minus placement and decimal point
    // ------------------------------------------------------------------
    logic    done_reg;
    result_t result_reg, result_next;

    logic [7:0] c0, c1, c2, c3;
    logic [7:0] pad;
    logic [7:0] f0, f1, f2, f3;

    always_comb
    begin
        // c0 is the leftmost (thousands) position, c3 the units
        c3  = digit_code(s4_d0_reg);
        c2  = digit_code(s4_d1_reg);
        c1  = digit_code(s4_d2_reg);
        c0  = digit_code(s4_d3_reg);
        pad = SEG_BLANK;
        f0  = SEG_BLANK;
        f1  = SEG_BLANK;
        f2  = SEG_BLANK;
        f3  = c3;

        if (!s4_ctl_reg.mode)
        begin
            pad = s4_ctl_reg.lz ? digit_code(4'd0) : SEG_BLANK;
            f2  = s4_show2_reg ? c2 : pad;
            f1  = s4_show1_reg ? c1 : pad;
            f0  = s4_show0_reg ? c0 : pad;
            if (s4_ctl_reg.neg_big)
            begin
                f0 = SEG_MINUS;
                f1 = SEG_MINUS;
                f2 = SEG_MINUS;
                f3 = SEG_MINUS;
            end
            else if (s4_ctl_reg.neg)
            begin
                // put the minus just left of the highest shown digit,
                // or over the leftmost padding zero
                if (s4_ctl_reg.lz || s4_show1_reg)
                    f0 = SEG_MINUS;
                else if (s4_show2_reg)
                    f1 = SEG_MINUS;
                else
                    f2 = SEG_MINUS;
            end
        end
        else
        begin
            f2 = s4_show2_reg ? c2 : SEG_BLANK;
            f1 = s4_show1_reg ? c1 : (s4_ctl_reg.neg ? digit_code(4'd0) : SEG_BLANK);
            f0 = s4_show0_reg ? c0 : SEG_BLANK;
            if (s4_ctl_reg.neg)
            begin
                // shift right and drop the units digit
                f3 = f2;
                f2 = f1;
                f1 = f0;
                f0 = SEG_MINUS;
            end
            case (s4_ctl_reg.dot)
                8'd1:    f0 = f0 | SEG_DOT;
                8'd2:    f1 = f1 | SEG_DOT;
                8'd3:    f2 = f2 | SEG_DOT;
                8'd4:    f3 = f3 | SEG_DOT;
                default: ;
            endcase
        end

        result_next.seg_first  = f0;
        result_next.seg_second = f1;
        result_next.seg_third  = f2;
        result_next.seg_fourth = f3;
    end

    // ------------------------------------------------------------------
    // Valid bits: reset clears them; advance every cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload: load only where an item is present
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_mag_reg <= s1_mag_next;
        end
        if (s1_valid_reg)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            s2_q_reg   <= s2_q_next;
            s2_d0_reg  <= s2_d0_next;
        end
        if (s2_valid_reg)
        begin
            s3_ctl_reg   <= s2_ctl_reg;
            s3_q_reg     <= s3_q_next;
            s3_d0_reg    <= s2_d0_reg;
            s3_d1_reg    <= s3_d1_next;
            s3_show2_reg <= s3_show2_next;
        end
        if (s3_valid_reg)
        begin
            s4_ctl_reg   <= s3_ctl_reg;
            s4_d0_reg    <= s3_d0_reg;
            s4_d1_reg    <= s3_d1_reg;
            s4_d2_reg    <= s4_d2_next;
            s4_d3_reg    <= s4_d3_next;
            s4_show2_reg <= s3_show2_reg;
            s4_show1_reg <= s4_show1_next;
            s4_show0_reg <= s4_show0_next;
        end
        if (s4_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/sits_checker.sv */
// ============================================================================
// sits_checker
// Port-level checks on the seven-segment unit, bound to the top level.
// ============================================================================
`include "signed_integer_to_seven_segment_unit_macros.svh"

module sits_checker
    import sits_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    done,
    input result_t result
);

    logic low_item;
    logic dashes_out;

    // integer mode item too far below zero to show with a sign
    assign low_item   = start && !busy && !item.mode && (item.number < -16'sd999);
    assign dashes_out = (result.seg_first == SEG_MINUS) && (result.seg_second == SEG_MINUS)
                        && (result.seg_third == SEG_MINUS)
                        && (result.seg_fourth == SEG_MINUS);

    `SITS_ASSERT_ALWAYS(a_never_busy, !busy)
    `SITS_ASSERT_IMPLY(a_item_gives_result, start && !busy, ##LATENCY done)
    `SITS_ASSERT_IMPLY(a_result_has_item, done, $past(start && !busy, LATENCY))
    `SITS_ASSERT_IMPLY(a_low_shows_minus, low_item, ##LATENCY dashes_out)

endmodule

bind signed_integer_to_seven_segment_unit sits_checker u_sits_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

/* dv/signed_integer_to_seven_segment_unit_tb.sv */
// ============================================================================
// signed_integer_to_seven_segment_unit_tb
// Self-checking testbench for the signed integer to seven-segment unit.
// The testbench drives numbers in both display modes, covering both padding
// styles and every decimal point position. It predicts the four segment
// codes for each accepted item and compares every strobed result, in order,
// against the oldest prediction.
// ============================================================================
module signed_integer_to_seven_segment_unit_tb;
    import sits_pkg::*;

    // Bound on consecutive cycles with no accepted item and no strobe.
    localparam int STALL_LIMIT = 1000;
    // Chance in percent that any one sender cycle idles.
    localparam int IDLE_PERCENT = 37;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Predicted segment codes, oldest first.
    result_t pending_segments[$];

    bit no_idle      = 1'b0;
    int items_sent   = 0;
    int mode1_items  = 0;
    int negative_items = 0;
    int results_checked = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    signed_integer_to_seven_segment_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Display predictor
    // ------------------------------------------------------------------------

    // Segment pattern of one decimal digit, a..g in bits 0..6.
    function automatic logic [7:0] glyph_for_digit(input int d);
        case (d)
            0:       return 8'h3F;
            1:       return 8'h06;
            2:       return 8'h5B;
            3:       return 8'h4F;
            4:       return 8'h66;
            5:       return 8'h6D;
            6:       return 8'h7D;
            7:       return 8'h07;
            8:       return 8'h7F;
            default: return 8'h6F;
        endcase
    endfunction

    // Work out the four codes, leftmost first, for one item.
    function automatic result_t encode_display(input item_t it);
        logic [7:0]  seg [4];
        logic [16:0] full_mag;
        int          rem;
        logic        neg;
        logic [7:0]  pad;
        bit          placed;
        result_t     r;
        neg      = it.number[15];
        full_mag = neg ? (NEG_BASE - {1'b0, it.number}) : {1'b0, it.number};
        rem      = (full_mag > 17'(MAG_LIMIT)) ? int'(MAG_LIMIT) : int'(full_mag);
        if (!it.mode && neg && full_mag > NEG_LIMIT)
        begin
            // Too wide to show with a sign: dashes across the display.
            for (int p = 0; p < 4; p++)
                seg[p] = SEG_MINUS;
        end
        else
        begin
            pad = (!it.mode && it.zero_pad) ? glyph_for_digit(0) : SEG_BLANK;
            // Fill from the right; the units digit always shows.
            for (int p = 3; p >= 0; p--)
            begin
                if (rem != 0 || p == 3)
                begin
                    seg[p] = glyph_for_digit(rem % 10);
                    rem    = rem / 10;
                end
                else if (it.mode && neg && p == 1)
                    seg[p] = glyph_for_digit(0);
                else
                    seg[p] = pad;
            end
            if (!it.mode)
            begin
                if (neg && it.zero_pad)
                    seg[0] = SEG_MINUS;
                else if (neg)
                begin
                    // Put the sign into the blank just left of the top digit.
                    placed = 1'b0;
                    for (int p = 0; p < 3; p++)
                    begin
                        if (!placed && seg[p + 1] != SEG_BLANK)
                        begin
                            seg[p] = SEG_MINUS;
                            placed = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                // Decimal mode shifts the whole display right under a sign,
                // losing the units digit.
                if (neg)
                begin
                    seg[3] = seg[2];
                    seg[2] = seg[1];
                    seg[1] = seg[0];
                    seg[0] = SEG_MINUS;
                end
                if (it.dot_pos >= 8'd1 && it.dot_pos <= 8'd4)
                    seg[it.dot_pos - 8'd1] = seg[it.dot_pos - 8'd1] | SEG_DOT;
            end
        end
        r.seg_first  = seg[0];
        r.seg_second = seg[1];
        r.seg_third  = seg[2];
        r.seg_fourth = seg[3];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic item_t make_item(input logic mode, input int number,
                                        input logic lz, input int dot);
        item_t it;
        it.mode     = mode;
        it.number   = 16'(number);
        it.zero_pad = lz;
        it.dot_pos  = 8'(dot);
        return it;
    endfunction

    // Pick a sign and a magnitude band so every digit count and the saturation
    // edges get fair weight.
    function automatic logic [15:0] pick_number();
        logic [15:0] m;
        logic        neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: m = 16'($urandom_range(0, 9));
            1: m = 16'($urandom_range(10, 999));
            2: m = 16'($urandom_range(1000, 9999));
            3: m = 16'($urandom_range(10000, 32768));
            4:
            begin
                case ($urandom_range(0, 5))
                    0:       m = 16'd999;
                    1:       m = 16'd1000;
                    2:       m = 16'd9999;
                    3:       m = 16'd10000;
                    4:       m = 16'd32767;
                    default: m = 16'd0;
                endcase
            end
            default: return 16'($urandom);
        endcase
        return neg ? (16'd0 - m) : m;
    endfunction

    function automatic item_t pick_item();
        item_t it;
        it.mode     = 1'($urandom_range(0, 1));
        it.number   = pick_number();
        it.zero_pad = 1'($urandom_range(0, 1));
        // Mostly the meaningful dot codes, sometimes any byte.
        it.dot_pos = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5))
                                                 : 8'($urandom);
        return it;
    endfunction

    // Idle cycles before the next item; each cycle idles with the same odds.
    function automatic int next_gap();
        int gap;
        gap = 0;
        if (no_idle)
            return 0;
        while ($urandom_range(0, 99) < IDLE_PERCENT)
            gap++;
        return gap;
    endfunction

    // Idle for gap cycles, then hold the item on the bus until accepted and
    // record its prediction. Leave start high so a following item can go
    // back to back.
    task automatic send_item(input item_t it, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_segments.push_back(encode_display(it));
        items_sent++;
        if (it.mode)
            mode1_items++;
        if (it.number[15])
            negative_items++;
    endtask

    // Drop start and hold off until every prediction has been matched, then
    // let the pipeline settle.
    task automatic wait_results_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_segments.size() != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corners: zero, one digit, digit-count edges, both saturation points,
    // the most negative code, both padding styles, and every dot code.
    task automatic test_directed_cases();
        item_t cases [$];
        cases.push_back(make_item(1'b0, 0, 1'b0, 255));
        cases.push_back(make_item(1'b0, 0, 1'b1, 0));
        cases.push_back(make_item(1'b0, 7, 1'b0, 3));
        cases.push_back(make_item(1'b0, -1, 1'b0, 1));
        cases.push_back(make_item(1'b0, -1, 1'b1, 2));
        cases.push_back(make_item(1'b0, -999, 1'b0, 4));
        cases.push_back(make_item(1'b0, -999, 1'b1, 0));
        cases.push_back(make_item(1'b0, -1000, 1'b0, 0));
        cases.push_back(make_item(1'b0, -32768, 1'b1, 0));
        cases.push_back(make_item(1'b0, 32767, 1'b0, 0));
        cases.push_back(make_item(1'b0, 9999, 1'b1, 0));
        cases.push_back(make_item(1'b0, 10000, 1'b0, 0));
        cases.push_back(make_item(1'b0, -10, 1'b0, 0));
        cases.push_back(make_item(1'b0, 1050, 1'b1, 0));
        cases.push_back(make_item(1'b1, 0, 1'b0, 0));
        cases.push_back(make_item(1'b1, 5, 1'b1, 1));
        cases.push_back(make_item(1'b1, 1234, 1'b0, 2));
        cases.push_back(make_item(1'b1, -1, 1'b0, 3));
        cases.push_back(make_item(1'b1, -5, 1'b1, 4));
        cases.push_back(make_item(1'b1, -32768, 1'b0, 5));
        cases.push_back(make_item(1'b1, 32767, 1'b0, 255));
        cases.push_back(make_item(1'b1, -999, 1'b1, 4));
        cases.push_back(make_item(1'b1, 9999, 1'b0, 1));
        cases.push_back(make_item(1'b1, -50, 1'b0, 2));
        cases.push_back(make_item(1'b1, -10000, 1'b1, 3));
        foreach (cases[i])
            send_item(cases[i], next_gap());
    endtask

    // Sign handling in both modes across every magnitude band.
    task automatic test_negative_numbers(input int count);
        item_t       it;
        logic [15:0] n;
        for (int i = 0; i < count; i++)
        begin
            it = pick_item();
            n  = pick_number();
            if (!n[15])
                n = 16'd0 - n;
            if (n == 16'd0)
                n = 16'hFFFF;
            it.number = n;
            send_item(it, next_gap());
        end
    endtask

    // Full rate: one item every cycle with no idling at all.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_item(pick_item(), 0);
        no_idle = 1'b0;
    endtask

    // Open random traffic with random idling on the sender.
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_item(pick_item(), next_gap());
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_seg(input string name, input logic [7:0] want,
                             input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Take every strobed result at the edge that ends its cycle and match it
    // against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_segments.size() == 0)
            begin
                $error("result strobed with no item outstanding: %h", result);
                mismatches++;
            end
            else
            begin
                want = pending_segments.pop_front();
                check_seg("seg_first", want.seg_first, result.seg_first);
                check_seg("seg_second", want.seg_second, result.seg_second);
                check_seg("seg_third", want.seg_third, result.seg_third);
                check_seg("seg_fourth", want.seg_fourth, result.seg_fourth);
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no activity for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        // Hold reset low from time zero, then release it on a rising edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        wait_results_drained();
        test_back_to_back(300);
        wait_results_drained();
        test_negative_numbers(300);
        wait_results_drained();
        test_random_mix(1225);

        // Drain the pipeline and watch for any stray strobe.
        wait_results_drained();

        $display("covered %0d items: %0d in decimal-point mode, %0d negative",
                 items_sent, mode1_items, negative_items);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/sits_pkg.sv
design/signed_integer_to_seven_segment_unit.sv
design/sits_checker.sv
dv/signed_integer_to_seven_segment_unit_tb.sv
